// ===== rtl/x86_branch_address_converter_core_macros.svh =====
// assertion macros used by the burst buffer of the branch address converter rtl
`ifndef X86_BRANCH_ADDRESS_CONVERTER_CORE_MACROS_SVH
`define X86_BRANCH_ADDRESS_CONVERTER_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define X86BCJ_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("x86bcj assertion failed");

// next-cycle implication, checked outside reset
`define X86BCJ_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("x86bcj assertion failed");

`endif

// ===== rtl/x86bcj_pkg.sv =====
// shared constants and types of the branch address converter
package x86bcj_pkg;

    localparam logic [7:0] OPCODE_CALL = 8'hE8;
    localparam logic [7:0] OPCODE_JMP  = 8'hE9;

    // operand is four bytes, the full instruction five
    localparam int OPERAND_BYTES = 4;
    localparam int INSTR_LEN     = 5;
    localparam logic [31:0] POS_ADJUST = 32'(INSTR_LEN - OPERAND_BYTES);

    // configuration register indexes
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] REG_ENCODE_MODE    = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_START_POSITION = 1'b1;

    // results caused by one item, byte 0 leaves first
    typedef struct packed {
        logic [2:0]      count;
        logic [3:0][7:0] bytes;
        logic            range_last;
    } burst_t;

endpackage

// ===== rtl/x86bcj_scan.sv =====
// opcode scan, operand gathering and displacement conversion
module x86bcj_scan (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 take,
    input  logic [7:0]           item_byte,
    input  logic                 item_last,
    input  logic                 encode_mode,
    input  logic [31:0]          start_position,
    output x86bcj_pkg::burst_t   burst
);
    import x86bcj_pkg::*;

    logic [31:0] byte_counter_reg, byte_counter_next;
    logic [1:0]  gathered_count_reg, gathered_count_next;
    logic        gathering_reg, gathering_next;
    logic [7:0]  operand_store_reg [3];
    logic        store_we;
    logic [31:0] pos, rel, conv;
    burst_t      res;

    assign pos  = start_position + byte_counter_reg + POS_ADJUST;
    assign rel  = {item_byte, operand_store_reg[2], operand_store_reg[1], operand_store_reg[0]};
    assign conv = encode_mode ? (rel + pos) : (rel - pos);

    always_comb begin
        res                 = '0;
        res.range_last      = item_last;
        store_we            = 1'b0;
        gathering_next      = gathering_reg;
        gathered_count_next = gathered_count_reg;
        byte_counter_next   = byte_counter_reg + 32'd1;
        if (!gathering_reg) begin
            res.count     = 3'd1;
            res.bytes[0]  = item_byte;
            if (item_byte == OPCODE_CALL || item_byte == OPCODE_JMP) begin
                gathering_next      = 1'b1;
                gathered_count_next = 2'd0;
            end
        end else if (gathered_count_reg != 2'd3) begin
            store_we            = 1'b1;
            gathered_count_next = gathered_count_reg + 2'd1;
            // range ends inside the operand: held bytes go out as they are
            if (item_last) begin
                res.count = {1'b0, gathered_count_reg} + 3'd1;
                for (int i = 0; i < 3; i++) begin
                    res.bytes[i] = (2'(i) == gathered_count_reg) ? item_byte
                                                                 : operand_store_reg[i];
                end
            end
        end else begin
            res.count           = 3'd4;
            res.bytes           = conv;
            gathering_next      = 1'b0;
            gathered_count_next = 2'd0;
        end
        if (item_last) begin
            byte_counter_next   = '0;
            gathered_count_next = 2'd0;
            gathering_next      = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_counter_reg   <= '0;
            gathered_count_reg <= 2'd0;
            gathering_reg      <= 1'b0;
        end else if (take) begin
            byte_counter_reg   <= byte_counter_next;
            gathered_count_reg <= gathered_count_next;
            gathering_reg      <= gathering_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take && store_we) begin
            operand_store_reg[gathered_count_reg] <= item_byte;
        end
    end

    assign burst = res;

endmodule

// ===== rtl/x86bcj_burst_buf.sv =====
// result register that sends a burst of up to four bytes one per cycle while m_ready is high
module x86bcj_burst_buf (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               load,
    input  x86bcj_pkg::burst_t load_burst,
    output logic               load_ready,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [7:0]         m_out_byte,
    output logic               m_burst_last,
    output logic               m_range_done
);
    import x86bcj_pkg::*;
    `include "x86_branch_address_converter_core_macros.svh"

    logic [2:0]      cnt_reg, cnt_next;
    logic [3:0][7:0] bytes_reg, bytes_next;
    logic            last_reg, last_next;
    logic            pop;

    assign pop        = m_valid && m_ready;
    assign load_ready = (cnt_reg == 3'd0) || (cnt_reg == 3'd1 && m_ready);

    always_comb begin
        cnt_next   = cnt_reg;
        bytes_next = bytes_reg;
        last_next  = last_reg;
        if (load) begin
            cnt_next   = load_burst.count;
            bytes_next = load_burst.bytes;
            last_next  = load_burst.range_last;
        end else if (pop) begin
            cnt_next   = cnt_reg - 3'd1;
            bytes_next = {8'h00, bytes_reg[3:1]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 3'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        bytes_reg <= bytes_next;
        last_reg  <= last_next;
    end

    assign m_valid      = (cnt_reg != 3'd0);
    assign m_out_byte   = bytes_reg[0];
    assign m_burst_last = (cnt_reg == 3'd1);
    assign m_range_done = (cnt_reg == 3'd1) && last_reg;

    `X86BCJ_ASSERT_NOW(a_cnt_in_range, aclk, aresetn, 1'b1, cnt_reg <= 3'd4)
    `X86BCJ_ASSERT_NOW(a_done_ends_burst, aclk, aresetn, m_valid && m_range_done, m_burst_last)
    `X86BCJ_ASSERT_NEXT(a_drain_empties, aclk, aresetn, cnt_reg == 3'd1 && m_ready && !load, cnt_reg == 3'd0)

endmodule

// ===== rtl/x86_branch_address_converter_core.sv =====
// top level of the x86 call/jump branch address converter
// Converts the 32-bit displacement after each call (0xE8) or jump (0xE9) opcode in a byte
// range, adding (encode) or subtracting (decode) start_position + opcode index + 5. One item
// is one byte; a pass-through byte gives one result, operand bytes give none until the fourth,
// which gives the four converted bytes, and a range that ends inside an operand flushes the held
// bytes unchanged. An accepted item passes through the input register, then the result
// register. Items are taken at one per cycle as long as each yields at most one result and
// m_ready is high; a four-byte burst drains from the result register at one byte per cycle
// while m_ready is high, and the next item waits until its last byte goes out. Configuration
// is written through cfg_wr_en / cfg_index / cfg_wr_data, effective at the next conversion.
module x86_branch_address_converter_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    // input byte stream
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [7:0]                         s_data_byte,
    input  logic                               s_range_last,
    // result byte stream
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [7:0]                         m_out_byte,
    output logic                               m_burst_last,
    output logic                               m_range_done,
    // configuration writes
    input  logic                               cfg_wr_en,
    input  logic [x86bcj_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]                        cfg_wr_data
);
    import x86bcj_pkg::*;

    // configuration registers
    logic        encode_mode_reg;
    logic [31:0] start_position_reg;

    // input register, frees the upstream side from the result stall
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;

    logic        take;
    logic        load_ready;
    burst_t      burst;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            encode_mode_reg    <= 1'b1;
            start_position_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_ENCODE_MODE:    encode_mode_reg    <= cfg_wr_data[0];
                REG_START_POSITION: start_position_reg <= cfg_wr_data;
            endcase
        end
    end

    // item moves on into the scan logic once the result register can take its burst
    assign take    = in_valid_reg && load_ready;
    assign s_ready = !in_valid_reg || take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (take) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_data_byte;
            in_last_reg <= s_range_last;
        end
    end

    // opcode scan and conversion, state advances once per item taken
    x86bcj_scan u_scan (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .take           (take),
        .item_byte      (in_byte_reg),
        .item_last      (in_last_reg),
        .encode_mode    (encode_mode_reg),
        .start_position (start_position_reg),
        .burst          (burst)
    );

    // result register, an item with no result loads an empty burst
    x86bcj_burst_buf u_burst_buf (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .load         (take),
        .load_burst   (burst),
        .load_ready   (load_ready),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_byte   (m_out_byte),
        .m_burst_last (m_burst_last),
        .m_range_done (m_range_done)
    );

endmodule

// ===== tb/x86_branch_address_converter_core_tb.sv =====
// self-checking testbench for the x86 call/jump branch address converter core
`timescale 1ns / 1ps

module x86_branch_address_converter_core_tb;
    import x86bcj_pkg::*;

    localparam int  SETTLE_CYCLES = 8;         // pipeline is two deep, give it room
    localparam int  LONG_HOLD     = 60;        // receiver back-pressure stretch
    localparam int  RAND_PHASES   = 5;
    localparam int  PHASE_ITEMS   = 41;
    localparam int  TIMEOUT_NS    = 5_000_000;
    localparam logic R_MID = 1'b0;             // byte inside a range
    localparam logic R_END = 1'b1;             // final byte of a range

    typedef struct packed {
        logic [7:0] data;
        logic       burst_last;
        logic       range_done;
    } out_rec_t;

    // tracks the converter state and the bytes it still owes us
    class branch_fixup_tracker;
        logic        encode_mode;
        logic [31:0] start_position;
        logic [31:0] byte_index;
        logic [7:0]  held [3];
        logic [1:0]  held_count;
        logic        gathering;
        out_rec_t    expected_bytes [$];
        int          errors;

        function new();
            encode_mode    = 1'b1;
            start_position = '0;
            byte_index     = '0;
            held_count     = '0;
            gathering      = 1'b0;
            errors         = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [31:0] value);
            if (idx == REG_ENCODE_MODE) begin
                encode_mode = value[0];
            end else if (idx == REG_START_POSITION) begin
                start_position = value;
            end
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction

        // accepted input byte: work out the bytes it releases
        function void note_byte(logic [7:0] b, logic last);
            out_rec_t    burst [$];
            out_rec_t    rec;
            logic [31:0] rel;
            logic [31:0] pos;
            logic [31:0] conv;
            int          n;
            rec = '0;
            if (!gathering) begin
                rec.data = b;
                burst = {burst, rec};
                if (b == OPCODE_CALL || b == OPCODE_JMP) begin
                    gathering  = 1'b1;
                    held_count = '0;
                end
            end else if (held_count < 2'd3) begin
                held[held_count] = b;
                held_count = held_count + 2'd1;
                // range cut short: held operand bytes go out untouched
                if (last) begin
                    for (int i = 0; i < held_count; i++) begin
                        rec.data = held[i];
                        burst = {burst, rec};
                    end
                end
            end else begin
                rel  = {b, held[2], held[1], held[0]};
                pos  = start_position + byte_index + POS_ADJUST;
                conv = encode_mode ? rel + pos : rel - pos;
                for (int i = 0; i < OPERAND_BYTES; i++) begin
                    rec.data = conv[8*i +: 8];
                    burst = {burst, rec};
                end
                gathering  = 1'b0;
                held_count = '0;
            end
            byte_index = byte_index + 32'd1;
            if (last) begin
                byte_index = '0;
                held_count = '0;
                gathering  = 1'b0;
            end
            n = burst.size();
            if (n > 0) begin
                rec = burst[n-1];
                rec.burst_last = 1'b1;
                rec.range_done = last;
                burst[n-1] = rec;
            end
            foreach (burst[i]) expected_bytes = {expected_bytes, burst[i]};
        endfunction

        function void check_out_byte(logic [7:0] data, logic bl, logic rd);
            out_rec_t want;
            if (expected_bytes.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected nothing, actual byte %h last %b done %b",
                         $time, data, bl, rd);
                return;
            end
            want = expected_bytes.pop_front();
            if (want.data !== data) begin
                errors++;
                $display("%0t: out_byte expected %h actual %h", $time, want.data, data);
            end
            if (want.burst_last !== bl) begin
                errors++;
                $display("%0t: burst_last expected %b actual %b", $time, want.burst_last, bl);
            end
            if (want.range_done !== rd) begin
                errors++;
                $display("%0t: range_done expected %b actual %b", $time, want.range_done, rd);
            end
        endfunction
    endclass

    logic                   aclk         = 1'b0;
    logic                   aresetn      = 1'b0;
    logic                   s_valid      = 1'b0;
    logic                   s_ready;
    logic [7:0]             s_data_byte  = '0;
    logic                   s_range_last = 1'b0;
    logic                   m_valid;
    logic                   m_ready      = 1'b0;
    logic [7:0]             m_out_byte;
    logic                   m_burst_last;
    logic                   m_range_done;
    logic                   cfg_wr_en    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index    = '0;
    logic [31:0]            cfg_wr_data  = '0;

    // idling controls, set by the main sequence; holds_done is counted by the result sink
    bit tx_stall_on   = 1'b0;
    bit rx_stall_on   = 1'b0;
    int hold_requests = 0;
    int holds_done    = 0;

    branch_fixup_tracker tracker;

    x86_branch_address_converter_core dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data_byte  (s_data_byte),
        .s_range_last (s_range_last),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_byte   (m_out_byte),
        .m_burst_last (m_burst_last),
        .m_range_done (m_range_done),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wr_data  (cfg_wr_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // mostly no gap, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 25);
    endfunction

    // opcodes are made common so operands get gathered often
    function automatic logic [7:0] rand_byte();
        if ($urandom_range(0, 99) < 20) return $urandom_range(0, 1) ? OPCODE_JMP : OPCODE_CALL;
        return 8'($urandom_range(0, 255));
    endfunction

    // observe handshakes at the edge: results first, then the new item, then writes
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) tracker.check_out_byte(m_out_byte, m_burst_last, m_range_done);
            if (s_valid && s_ready) tracker.note_byte(s_data_byte, s_range_last);
            if (cfg_wr_en) tracker.write_reg(cfg_index, cfg_wr_data);
        end
    end

    // result side ready, with random stalls and the occasional long hold-off
    initial begin : result_sink
        int gap;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (holds_done != hold_requests) begin
                holds_done++;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end else if (rx_stall_on && $urandom_range(0, 3) == 0) begin
                gap = pick_gap() + 1;
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
        end
    end

    // offer one item, holding valid until it is taken
    task automatic push_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = tx_stall_on ? pick_gap() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_data_byte  <= b;
        s_range_last <= last;
        do @(posedge aclk); while (!s_ready);
    endtask

    // all owed bytes out, then let any operand byte still in flight settle
    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (tracker.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic load_config(input logic enc, input logic [31:0] start);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= REG_ENCODE_MODE;
        cfg_wr_data <= {31'b0, enc};
        @(posedge aclk);
        cfg_index   <= REG_START_POSITION;
        cfg_wr_data <= start;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial begin : main_seq
        // {range_last, byte}: plain bytes, full operands, opcode bytes inside an operand,
        // opcode as the last byte of a range
        static logic [8:0] dir_enc [17] = '{
            {R_MID, 8'h00},
            {R_MID, OPCODE_CALL}, {R_MID, 8'h11}, {R_MID, 8'h22}, {R_MID, 8'h33},
            {R_MID, 8'h44},
            {R_MID, OPCODE_JMP}, {R_MID, 8'hFF}, {R_MID, 8'hFF}, {R_MID, 8'hFF},
            {R_MID, 8'hFF},
            {R_MID, OPCODE_CALL}, {R_MID, OPCODE_CALL}, {R_MID, OPCODE_JMP},
            {R_MID, OPCODE_CALL}, {R_MID, OPCODE_CALL},
            {R_END, OPCODE_JMP}
        };
        // ranges that end with one and with three operand bytes held
        static logic [8:0] dir_cut [6] = '{
            {R_MID, OPCODE_CALL}, {R_END, 8'hAA},
            {R_MID, OPCODE_JMP}, {R_MID, 8'hAA}, {R_MID, 8'hBB}, {R_END, 8'hCC}
        };
        logic        enc;
        logic [31:0] start;

        tracker = new();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: encode from offset zero, no idling
        load_config(1'b1, 32'h0000_0000);
        foreach (dir_enc[i]) push_byte(dir_enc[i][7:0], dir_enc[i][8]);
        wait_idle();

        // directed: decode near the top of the address space, with idling
        tx_stall_on = 1'b1;
        rx_stall_on = 1'b1;
        load_config(1'b0, 32'hFFFF_FFFF);
        foreach (dir_cut[i]) push_byte(dir_cut[i][7:0], dir_cut[i][8]);
        wait_idle();

        // random ranges under several settings; phases may split a range
        for (int p = 0; p < RAND_PHASES; p++) begin
            unique case (p)
                0: begin enc = 1'b1; start = 32'hFFFF_FFFF; end
                1: begin enc = 1'b0; start = 32'h0000_0000; end
                2: begin enc = 1'b0; start = $urandom; end
                3: begin enc = 1'b1; start = $urandom; end
                default: begin enc = 1'($urandom_range(0, 1)); start = 32'h8000_0000; end
            endcase
            tx_stall_on = (p != 0);
            rx_stall_on = (p != 0);
            load_config(enc, start);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                // stall the receiver long enough for the input to back up
                if (p == 2 && i == 10) hold_requests++;
                push_byte(rand_byte(), $urandom_range(0, 11) == 0);
            end
            wait_idle();
        end

        if (tracker.errors == 0) begin
            $display("x86_branch_address_converter_core_tb: done, clean");
        end else begin
            $display("x86_branch_address_converter_core_tb: done, errors");
        end
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("x86_branch_address_converter_core_tb: done, errors");
        $finish;
    end

endmodule
